// ===== rtl/slir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package slir_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W  = 6;

    typedef enum logic [1:0] {
        OP_INSERT    = 2'd0,
        OP_REMOVE    = 2'd1,
        OP_LIST_ASC  = 2'd2,
        OP_LIST_DESC = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_ELEMENT  = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_LIST_RD,
        S_LIST_OUT,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/sorted_list_insert_remove_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sorted list of signed 32-bit values kept in ascending order, duplicates allowed.
// The input channel (i_valid / o_stall) carries one beat per command: insert,
// remove, list ascending or list descending. The output channel (o_valid /
// i_stall) returns one beat per insert or remove, and one beat per stored value
// (or a single "empty" beat) for a list command; o_last marks the final beat.
// Commands run one at a time on a single-port entry memory with registered read
// data and one compare per scanned entry, so o_stall is high while a command is busy.
// Each memory visit is split into an address step and a step that uses the read data.
// An insert scans to the first entry not below the value, shifts that entry and all
// above it up by one slot and puts the value there, or after the last entry if none.
// A remove scans to the first match, then shifts the entries above it down by one.
// A full insert, an empty list or a remove on an empty list skips the memory entirely.
// The result sits in an output register, so the core returns to idle and takes
// the next command while the last beat still waits; a stall from the receiver
// only holds the sequencer at the point where it needs to load a new beat.
// Reset clears the element count, the sequencer state and the output valid flag;
// the entry memory is not cleared, since only entries below the count are ever read.
module sorted_list_insert_remove_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [31:0]      o_element,
    output logic [5:0]       o_position,
    output logic             o_last
);

    // Entry memory and its registered read port.
    logic [slir_pkg::DATA_W-1:0] r_mem [slir_pkg::DEPTH];
    logic [slir_pkg::DATA_W-1:0] r_rdata;

    logic                        w_we;
    logic                        w_re;
    logic [slir_pkg::IDX_W-1:0]  w_waddr;
    logic [slir_pkg::IDX_W-1:0]  w_raddr;
    logic [slir_pkg::DATA_W-1:0] w_wdata;

    // Sequencer state and the command being worked on.
    slir_pkg::t_state            r_state, n_state;
    slir_pkg::t_op               r_op, n_op;
    logic [slir_pkg::DATA_W-1:0] r_val, n_val;
    logic [slir_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [slir_pkg::IDX_W-1:0]  r_pos, n_pos;
    logic [slir_pkg::CNT_W-1:0]  r_count, n_count;
    slir_pkg::t_status           r_st, n_st;

    // Output register.
    logic                        r_o_valid, n_o_valid;
    slir_pkg::t_status           r_o_status, n_o_status;
    logic [slir_pkg::DATA_W-1:0] r_o_element, n_o_element;
    logic [slir_pkg::POS_W-1:0]  r_o_position, n_o_position;
    logic                        r_o_last, n_o_last;

    logic                        w_out_free;
    logic [slir_pkg::CNT_W-1:0]  w_idx_ext;
    logic                        w_list_last;

    assign w_out_free = !r_o_valid || !i_stall;
    assign w_idx_ext  = slir_pkg::CNT_W'(r_idx);
    assign o_stall    = (r_state != slir_pkg::S_IDLE);

    assign o_valid    = r_o_valid;
    assign o_status   = r_o_status;
    assign o_element  = r_o_element;
    assign o_position = r_o_position;
    assign o_last     = r_o_last;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= slir_pkg::S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_op         <= n_op;
        r_val        <= n_val;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_st         <= n_st;
        r_o_status   <= n_o_status;
        r_o_element  <= n_o_element;
        r_o_position <= n_o_position;
        r_o_last     <= n_o_last;
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_val        = r_val;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_count      = r_count;
        n_st         = r_st;
        n_o_valid    = r_o_valid && i_stall;
        n_o_status   = r_o_status;
        n_o_element  = r_o_element;
        n_o_position = r_o_position;
        n_o_last     = r_o_last;
        w_we         = 1'b0;
        w_re         = 1'b0;
        w_waddr      = r_idx;
        w_raddr      = r_idx;
        w_wdata      = r_rdata;
        w_list_last  = 1'b0;

        unique case (r_state)
            slir_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_op  = slir_pkg::t_op'(i_operation);
                    n_val = i_value;
                    n_idx = '0;
                    n_pos = '0;
                    unique case (slir_pkg::t_op'(i_operation))
                        slir_pkg::OP_INSERT: begin
                            if (r_count == slir_pkg::CNT_W'(slir_pkg::DEPTH)) begin
                                n_st    = slir_pkg::ST_FULL;
                                n_state = slir_pkg::S_EMIT;
                            end else if (r_count == '0) begin
                                n_state = slir_pkg::S_PUT;
                            end else begin
                                n_state = slir_pkg::S_SCAN_RD;
                            end
                        end
                        slir_pkg::OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_st    = slir_pkg::ST_NOTFOUND;
                                n_state = slir_pkg::S_EMIT;
                            end else begin
                                n_state = slir_pkg::S_SCAN_RD;
                            end
                        end
                        slir_pkg::OP_LIST_ASC, slir_pkg::OP_LIST_DESC: begin
                            if (r_count == '0) begin
                                n_st    = slir_pkg::ST_EMPTY;
                                n_val   = '0;
                                n_state = slir_pkg::S_EMIT;
                            end else begin
                                if (slir_pkg::t_op'(i_operation) == slir_pkg::OP_LIST_DESC) begin
                                    n_idx = slir_pkg::IDX_W'(r_count - 1'b1);
                                end
                                n_state = slir_pkg::S_LIST_RD;
                            end
                        end
                        default: begin
                            n_state = slir_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            slir_pkg::S_SCAN_RD: begin
                w_re    = 1'b1;
                n_state = slir_pkg::S_SCAN_CHK;
            end

            slir_pkg::S_SCAN_CHK: begin
                // One compare per visited entry; the first hit ends the scan.
                if (r_op == slir_pkg::OP_INSERT) begin
                    if ($signed(r_rdata) >= $signed(r_val)) begin
                        n_pos   = r_idx;
                        n_idx   = slir_pkg::IDX_W'(r_count);
                        n_state = slir_pkg::S_SHIFT_RD;
                    end else if (w_idx_ext + 1'b1 == r_count) begin
                        n_pos   = slir_pkg::IDX_W'(r_count);
                        n_state = slir_pkg::S_PUT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = slir_pkg::S_SCAN_RD;
                    end
                end else begin
                    if (r_rdata == r_val) begin
                        n_pos = r_idx;
                        n_st  = slir_pkg::ST_REMOVED;
                        if (w_idx_ext + 1'b1 < r_count) begin
                            n_state = slir_pkg::S_SHIFT_RD;
                        end else begin
                            n_count = r_count - 1'b1;
                            n_state = slir_pkg::S_EMIT;
                        end
                    end else if (w_idx_ext + 1'b1 == r_count) begin
                        n_pos   = '0;
                        n_st    = slir_pkg::ST_NOTFOUND;
                        n_state = slir_pkg::S_EMIT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = slir_pkg::S_SCAN_RD;
                    end
                end
            end

            slir_pkg::S_SHIFT_RD: begin
                // r_idx is the slot being written; its source is the neighbor.
                w_re = 1'b1;
                if (r_op == slir_pkg::OP_INSERT) begin
                    w_raddr = r_idx - 1'b1;
                end else begin
                    w_raddr = r_idx + 1'b1;
                end
                n_state = slir_pkg::S_SHIFT_WR;
            end

            slir_pkg::S_SHIFT_WR: begin
                w_we = 1'b1;
                if (r_op == slir_pkg::OP_INSERT) begin
                    if (r_idx - 1'b1 == r_pos) begin
                        n_state = slir_pkg::S_PUT;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = slir_pkg::S_SHIFT_RD;
                    end
                end else begin
                    if (w_idx_ext + 2'd2 >= r_count) begin
                        n_count = r_count - 1'b1;
                        n_state = slir_pkg::S_EMIT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = slir_pkg::S_SHIFT_RD;
                    end
                end
            end

            slir_pkg::S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_pos;
                w_wdata = r_val;
                n_count = r_count + 1'b1;
                n_st    = slir_pkg::ST_INSERTED;
                n_state = slir_pkg::S_EMIT;
            end

            slir_pkg::S_LIST_RD: begin
                w_re    = 1'b1;
                n_state = slir_pkg::S_LIST_OUT;
            end

            slir_pkg::S_LIST_OUT: begin
                if (r_op == slir_pkg::OP_LIST_ASC) begin
                    w_list_last = (w_idx_ext + 1'b1 == r_count);
                end else begin
                    w_list_last = (r_idx == '0);
                end
                if (w_out_free) begin
                    n_o_valid    = 1'b1;
                    n_o_status   = slir_pkg::ST_ELEMENT;
                    n_o_element  = r_rdata;
                    n_o_position = slir_pkg::POS_W'(r_idx);
                    n_o_last     = w_list_last;
                    if (w_list_last) begin
                        n_state = slir_pkg::S_IDLE;
                    end else begin
                        if (r_op == slir_pkg::OP_LIST_ASC) begin
                            n_idx = r_idx + 1'b1;
                        end else begin
                            n_idx = r_idx - 1'b1;
                        end
                        n_state = slir_pkg::S_LIST_RD;
                    end
                end
            end

            slir_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_o_valid    = 1'b1;
                    n_o_status   = r_st;
                    n_o_element  = r_val;
                    n_o_position = slir_pkg::POS_W'(r_pos);
                    n_o_last     = 1'b1;
                    n_state      = slir_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = slir_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== dv/tb_sorted_list_insert_remove_core.sv =====
`timescale 1ns / 1ps

module tb_sorted_list_insert_remove_core;

    import slir_pkg::*;

    // Slowest correct run: about 110 commands, random and directed together.
    // A list of 16 beats waits on a receiver that stalls half the time. Even so,
    // such a run stays far below this limit.
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 64;

    // One output beat as the list mirror predicts it.
    typedef struct {
        t_status     status;
        logic [31:0] element;
        logic [5:0]  position;
        logic        last;
    } list_beat_t;

    // Mirror of the sorted list. Every accepted command updates the stored
    // values and queues the beats that the core must return for it. Returned
    // beats are checked in order against that queue.
    class sorted_list_mirror;
        logic [31:0] stored [DEPTH];
        int          fill;
        list_beat_t  pending_beats [$];
        int          failures;

        function new();
            fill = 0;
            failures = 0;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void queue_beat(t_status status, logic [31:0] element, int position,
                                 logic last);
            list_beat_t b;
            b.status = status;
            b.element = element;
            b.position = position[5:0];
            b.last = last;
            pending_beats.push_back(b);
        endfunction

        function logic [31:0] pick_stored();
            return stored[$urandom_range(fill - 1)];
        endfunction

        function void note_command(t_op op, logic [31:0] value);
            int slot;
            bit hit;
            slot = fill;
            hit = 1'b0;
            case (op)
                OP_INSERT: begin
                    if (fill >= DEPTH) begin
                        queue_beat(ST_FULL, value, 0, 1'b1);
                    end else begin
                        // The new value goes in front of the first value
                        // that is not smaller than it.
                        for (int i = 0; i < fill; i++) begin
                            if (!hit && $signed(stored[i]) >= $signed(value)) begin
                                slot = i;
                                hit = 1'b1;
                            end
                        end
                        for (int i = fill; i > slot; i--) begin
                            stored[i] = stored[i - 1];
                        end
                        stored[slot] = value;
                        fill++;
                        queue_beat(ST_INSERTED, value, slot, 1'b1);
                    end
                end
                OP_REMOVE: begin
                    for (int i = 0; i < fill; i++) begin
                        if (!hit && stored[i] == value) begin
                            slot = i;
                            hit = 1'b1;
                        end
                    end
                    if (!hit) begin
                        queue_beat(ST_NOTFOUND, value, 0, 1'b1);
                    end else begin
                        for (int i = slot; i + 1 < fill; i++) begin
                            stored[i] = stored[i + 1];
                        end
                        fill--;
                        queue_beat(ST_REMOVED, value, slot, 1'b1);
                    end
                end
                default: begin
                    if (fill == 0) begin
                        queue_beat(ST_EMPTY, '0, 0, 1'b1);
                    end else begin
                        for (int i = 0; i < fill; i++) begin
                            slot = (op == OP_LIST_ASC) ? i : fill - 1 - i;
                            queue_beat(ST_ELEMENT, stored[slot], slot, i + 1 == fill);
                        end
                    end
                end
            endcase
        endfunction

        function void check_beat(logic [2:0] status, logic [31:0] element,
                                 logic [5:0] position, logic last);
            list_beat_t want;
            if (pending_beats.size() == 0) begin
                flag($sformatf("unexpected beat: status %0d element %0d position %0d last %0b",
                               status, $signed(element), position, last));
            end else begin
                want = pending_beats.pop_front();
                if (status !== want.status || element !== want.element ||
                    position !== want.position || last !== want.last) begin
                    flag($sformatf({"mismatch: expected status %0d element %0d position %0d",
                                    " last %0b, got status %0d element %0d position %0d",
                                    " last %0b"},
                                   want.status, $signed(want.element), want.position,
                                   want.last, status, $signed(element), position, last));
                end
            end
        endfunction

        function void flag_leftovers();
            if (pending_beats.size() != 0) begin
                flag($sformatf("%0d expected beats never arrived", pending_beats.size()));
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_operation = OP_INSERT;
    logic [31:0] i_value = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [31:0] o_element;
    logic [5:0]  o_position;
    logic        o_last;

    sorted_list_mirror sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;

    sorted_list_insert_remove_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_operation(i_operation),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_element  (o_element),
        .o_position (o_position),
        .o_last     (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // The receiver stalls at random. Like every other input, it changes only
    // at the falling edge.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Both channels are observed at the rising edge, before the core's own
    // updates land. An output beat is checked first, then an accepted command
    // is handed to the mirror. No command can produce a beat at the same edge
    // at which it is accepted, so this order is safe.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                sb.check_beat(o_status, o_element, o_position, o_last);
            end
            if (i_valid && !o_stall) begin
                sb.note_command(t_op'(i_operation), i_value);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sorted_list_insert_remove_core regression: fail");
            $finish;
        end
    end

    // Values cluster around zero so that duplicates and hits on remove are
    // common. The extremes of the signed range and fully random words fill
    // out the rest.
    function automatic logic [31:0] spread_value();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5) begin
            return 32'($signed($urandom_range(6)) - 3);
        end else if (pick == 5) begin
            case ($urandom_range(3))
                0: return 32'h7fff_ffff;
                1: return 32'h8000_0000;
                2: return 32'hffff_ffff;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom();
    endfunction

    // Sends one command. The task is entered at a falling edge and returns at
    // one. i_valid is written at most once per edge, so back-to-back commands
    // keep it high without a glitch.
    task automatic send_command(t_op op, logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Random commands, weighted by phase. Most removes name a value that is
    // actually stored, so that the shift logic gets exercised. The rest go
    // after values that are likely missing.
    task automatic run_random(int n_items, int ins_pct, int rem_pct);
        int r;
        t_op op;
        logic [31:0] value;
        repeat (n_items) begin
            r = $urandom_range(99);
            if (r < ins_pct) begin
                op = OP_INSERT;
                value = spread_value();
            end else if (r < ins_pct + rem_pct) begin
                op = OP_REMOVE;
                value = (sb.fill > 0 && $urandom_range(9) < 7) ? sb.pick_stored()
                                                               : spread_value();
            end else begin
                op = $urandom_range(1) ? OP_LIST_DESC : OP_LIST_ASC;
                value = $urandom();
            end
            send_command(op, value);
        end
    endtask

    initial begin
        sb = new();
        send_idle_pct = 21;
        recv_stall_pct = 52;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // An empty list answers a list command with a single empty beat, and
        // a remove on an empty list reports not found.
        send_command(OP_LIST_ASC, 32'h1234_5678);
        send_command(OP_LIST_DESC, 32'hffff_ffff);
        send_command(OP_REMOVE, 32'h0000_0000);

        // Extremes of the signed range, plus a duplicate zero.
        send_command(OP_INSERT, 32'h7fff_ffff);
        send_command(OP_INSERT, 32'h8000_0000);
        send_command(OP_INSERT, 32'h0000_0000);
        send_command(OP_INSERT, 32'h0000_0000);
        send_command(OP_INSERT, 32'hffff_ffff);
        send_command(OP_LIST_ASC, 32'h0000_0000);

        // The remove takes out the first of the two zeros. The second remove
        // names a value that is not stored.
        send_command(OP_REMOVE, 32'h0000_0000);
        send_command(OP_REMOVE, 32'h0000_0005);

        // The list is filled to capacity. The next insert must be rejected
        // as full, and the list must come back whole in descending order.
        while (sb.fill < DEPTH) begin
            send_command(OP_INSERT, spread_value());
        end
        send_command(OP_INSERT, 32'h7fff_ffff);
        send_command(OP_LIST_DESC, 32'h0000_0000);
        send_command(OP_REMOVE, 32'h8000_0000);

        // Random part, in three phases. In the first phase the sender idles
        // lightly and the receiver often stalls, and inserts dominate, so the
        // list stays near full. In the second the roles swap and removes drain
        // the list. In the third nobody idles.
        run_random(28, 55, 25);
        send_idle_pct = 52;
        recv_stall_pct = 21;
        run_random(28, 25, 50);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random(28, 45, 35);
        i_valid <= 1'b0;

        while (sb.pending_beats.size() != 0) begin
            @(posedge i_clk);
        end
        // A few more cycles so that a stray extra beat would still be caught.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.flag_leftovers();
        if (sb.failures == 0) begin
            $display("sorted_list_insert_remove_core regression: pass");
        end else begin
            $display("sorted_list_insert_remove_core regression: fail");
        end
        $finish;
    end

endmodule
